// ===== design/rcbe_pkg.sv =====
`default_nettype none

package rcbe_pkg;

   // Field and register widths.
   localparam int CRC_W     = 32;
   localparam int HALF_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 2;

   // Remainder masks for the two width modes.
   localparam logic [CRC_W-1:0] MASK16 = 32'h0000_FFFF;
   localparam logic [CRC_W-1:0] MASK32 = 32'hFFFF_FFFF;

   // Register reset values.
   localparam logic [CRC_W-1:0] POLY_RESET  = 32'hEDB8_8320;
   localparam logic             WIDTH_RESET = 1'b1;
   localparam logic [CRC_W-1:0] START_RESET = 32'h0000_0000;

   // Width mode codes.
   localparam logic WIDTH_16 = 1'b0;
   localparam logic WIDTH_32 = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLYNOMIAL  = 2'd0,
      CSR_WIDTH_MODE  = 2'd1,
      CSR_START_VALUE = 2'd2
   } csr_index_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [CRC_W-1:0] polynomial;
      logic             width_mode;
      logic [CRC_W-1:0] start_value;
   } crc_cfg_type;

endpackage

`default_nettype wire

// ===== design/rcbe_csr.sv =====
`default_nettype none

module rcbe_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [rcbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rcbe_pkg::CRC_W-1:0]    csr_wdata,
   output      rcbe_pkg::crc_cfg_type         cfg
);
   import rcbe_pkg::*;

   logic [CRC_W-1:0] polynomial_ff,  polynomial_in;
   logic             width_mode_ff,  width_mode_in;
   logic [CRC_W-1:0] start_value_ff, start_value_in;

   // Decode a write; an index beyond the register list changes nothing.
   always_comb begin
      polynomial_in  = polynomial_ff;
      width_mode_in  = width_mode_ff;
      start_value_in = start_value_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_POLYNOMIAL:  polynomial_in  = csr_wdata;
            CSR_WIDTH_MODE:  width_mode_in  = csr_wdata[0];
            CSR_START_VALUE: start_value_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Register storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         polynomial_ff  <= POLY_RESET;
         width_mode_ff  <= WIDTH_RESET;
         start_value_ff <= START_RESET;
      end else begin
         polynomial_ff  <= polynomial_in;
         width_mode_ff  <= width_mode_in;
         start_value_ff <= start_value_in;
      end
   end

   assign cfg.polynomial  = polynomial_ff;
   assign cfg.width_mode  = width_mode_ff;
   assign cfg.start_value = start_value_ff;

endmodule

`default_nettype wire

// ===== design/rcbe_fold.sv =====
`default_nettype none

module rcbe_fold (
   input  wire rcbe_pkg::crc_cfg_type      cfg,
   input  wire logic [rcbe_pkg::CRC_W-1:0] cur_remainder,
   input  wire logic [rcbe_pkg::BYTE_W-1:0] data_byte,
   input  wire logic                       first_byte,
   output      logic [rcbe_pkg::CRC_W-1:0] next_remainder
);
   import rcbe_pkg::*;

   logic [CRC_W-1:0] mask;
   logic [CRC_W-1:0] poly;
   logic [CRC_W-1:0] r;

   // Pick the width mask and the polynomial restricted to it.
   assign mask = (cfg.width_mode == WIDTH_32) ? MASK32 : MASK16;
   assign poly = cfg.polynomial & mask;

   // Load the seed, XOR the byte in, then run eight LSB-first division steps.
   always_comb begin
      r = (first_byte ? cfg.start_value : cur_remainder) & mask;
      r = r ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
      for (int k = 0; k < BYTE_W; k++) begin
         if (r[0]) begin
            r = (r >> 1) ^ poly;
         end else begin
            r = r >> 1;
         end
      end
      next_remainder = r & mask;
   end

endmodule

`default_nettype wire

// ===== design/reflected_crc_byte_engine_core.sv =====
`default_nettype none

// Reflected CRC engine: one message byte per transaction on the req_ stream,
// one remainder per byte on the rsp_ stream. req_tuser marks the first byte
// of a message (the configured start value is loaded first) and req_tlast the
// last one, which comes back as rsp_tlast. The engine sustains one byte per
// clock cycle while rsp_tready stays high: the byte sits in an input register,
// the full eight-step fold runs combinationally from there into the result
// register and the running remainder, and rsp_tvalid rises once the result
// register has loaded. The result register holds while rsp_tready is low and
// the input register can still take one more byte. Width mode 0 gives a 16-bit
// remainder, returned zero-extended. There is no initial or final inversion.
// Write the csr_ registers only while no bytes are in flight.
module reflected_crc_byte_engine_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Input stream.
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,  // [7:0] data_byte
   input  wire logic                           req_tuser,  // [0] first_byte
   input  wire logic                           req_tlast,  // last_byte
   // Result stream.
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   output      logic [31:0]                    rsp_tdata,  // [31:0] crc_value
   output      logic                           rsp_tlast,  // message_done
   // Configuration writes.
   input  wire logic                           csr_we,
   input  wire logic [rcbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rcbe_pkg::CRC_W-1:0]     csr_wdata
);
   import rcbe_pkg::*;

   crc_cfg_type cfg;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff,  s1_byte_in;
   logic              s1_first_ff, s1_first_in;
   logic              s1_last_ff,  s1_last_in;

   logic              s2_valid_ff, s2_valid_in;
   logic [CRC_W-1:0]  s2_crc_ff,   s2_crc_in;
   logic              s2_last_ff,  s2_last_in;

   logic [CRC_W-1:0]  remainder_ff, remainder_in;
   logic [CRC_W-1:0]  next_remainder;

   logic              s2_load;
   logic              req_take;

   rcbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rcbe_fold u_fold (
      .cfg            (cfg),
      .cur_remainder  (remainder_ff),
      .data_byte      (s1_byte_ff),
      .first_byte     (s1_first_ff),
      .next_remainder (next_remainder)
   );

   // Flow control: the result register loads when it is empty or being
   // drained, and the input register takes a byte when it is empty or moving.
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_load;
   assign req_take   = req_tvalid && req_tready;

   // Input register next values.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_first_in = s1_first_ff;
      s1_last_in  = s1_last_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_first_in = req_tuser;
         s1_last_in  = req_tlast;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end
   end

   // Result register and running remainder next values.
   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_crc_in    = s2_crc_ff;
      s2_last_in   = s2_last_ff;
      remainder_in = remainder_ff;
      if (s2_load) begin
         s2_valid_in  = 1'b1;
         s2_crc_in    = next_remainder;
         s2_last_in   = s1_last_ff;
         remainder_in = next_remainder;
      end else if (rsp_tready) begin
         s2_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         remainder_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         remainder_ff <= remainder_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_first_ff <= s1_first_in;
      s1_last_ff  <= s1_last_in;
      s2_crc_ff   <= s2_crc_in;
      s2_last_ff  <= s2_last_in;
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = s2_crc_ff;
   assign rsp_tlast  = s2_last_ff;

`ifndef ASSERT_OFF
   // The running remainder always matches the last result loaded.
   a_remainder_tracks: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> (remainder_ff == rsp_tdata))
      else $error("remainder does not match loaded result");

   // A 16-bit result never carries bits above the low half.
   a_half_width: assert property (@(posedge clock) disable iff (reset)
      (s2_load && (cfg.width_mode == WIDTH_16)) |=> (rsp_tdata[CRC_W-1:HALF_W] == '0))
      else $error("16-bit result has upper bits set");

   // A byte waiting in the input register is not dropped while blocked.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> s1_valid_ff)
      else $error("input byte lost while result stage was full");

   // A result that was not taken stays presented.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("pending result changed before it was taken");
`endif

endmodule

`default_nettype wire

// ===== tb/reflected_crc_byte_engine_core_tb.sv =====
`default_nettype none

module reflected_crc_byte_engine_core_tb;
   import rcbe_pkg::*;

   // Index that maps to no register; a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Kinds of rows in the directed table.
   typedef enum logic {
      ROW_BYTE = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [CRC_W-1:0]       value;
      logic [BYTE_W-1:0]      data;
      logic                   first;
      logic                   last;
      logic                   has_crc;
      logic [CRC_W-1:0]       crc;
   } directed_row_type;

   typedef struct packed {
      logic [CRC_W-1:0] crc;
      logic             done;
   } crc_result_type;

   localparam int NUM_ROWS = 24;

   // Directed rows: reset behavior, extremes of bytes and registers, width change
   // mid-message, bytes after the last one and a write to the unused index.
   localparam directed_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h00, 1'b0, 1'b0, 1'b1, 32'h0000_0000},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h80, 1'b1, 1'b0, 1'b1, 32'hEDB8_8320},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'hFF, 1'b1, 1'b1, 1'b1, 32'h2D02_EF8D},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h01, 1'b0, 1'b1, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h5A, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_WIDTH_MODE, {31'b0, WIDTH_16}, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h3C, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h80, 1'b1, 1'b0, 1'b1, 32'h0000_8320},
      '{ROW_CSR, CSR_START_VALUE, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'hFF, 1'b0, 1'b1, 1'b0, 32'h0},
      '{ROW_CSR, CSR_POLYNOMIAL, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'hA5, 1'b1, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_WIDTH_MODE, {31'b0, WIDTH_32}, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'hFF, 1'b1, 1'b1, 1'b0, 32'h0},
      '{ROW_CSR, CSR_POLYNOMIAL, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h80, 1'b1, 1'b0, 1'b1, 32'h00FF_FFFF},
      '{ROW_CSR, CSR_UNUSED, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h55, 1'b0, 1'b1, 1'b0, 32'h0},
      '{ROW_CSR, CSR_POLYNOMIAL, 32'h0000_0001, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'hAA, 1'b1, 1'b0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_START_VALUE, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{ROW_BYTE, CSR_UNUSED, 32'h0, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0000}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // [7:0] data_byte
   logic                 req_tuser;   // [0] first_byte
   logic                 req_tlast;   // last_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [31:0]          rsp_tdata;   // [31:0] crc_value
   logic                 rsp_tlast;   // message_done
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CRC_W-1:0]     csr_wdata;

   // Shadow copy of the engine's registers and running remainder.
   logic [CRC_W-1:0] crc_poly;
   logic             crc_wide;
   logic [CRC_W-1:0] crc_start;
   logic [CRC_W-1:0] crc_remainder;

   crc_result_type   crc_expect_q[$];
   crc_result_type   crc_expected;

   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned bytes_sent;
   int unsigned results_checked;
   int unsigned messages_sent;
   int unsigned csr_writes;
   int unsigned mismatch_count;

   reflected_crc_byte_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // The receiver drops ready at random at the current idle rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Fold one byte into a remainder, LSB first, eight shift-xor steps.
   function automatic logic [CRC_W-1:0] fold_crc_byte(input logic [CRC_W-1:0] rem,
                                                      input logic [BYTE_W-1:0] data,
                                                      input logic [CRC_W-1:0] poly);
      logic [CRC_W-1:0] r;
      r = rem ^ {24'b0, data};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
      end
      return r;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   // Every result transaction is checked against the oldest expected remainder.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (crc_expect_q.size() == 0) begin
            note_mismatch($sformatf("result crc=%08h done=%0b with none expected",
                                    rsp_tdata, rsp_tlast));
         end else begin
            crc_expected = crc_expect_q.pop_front();
            results_checked++;
            if (rsp_tdata !== crc_expected.crc || rsp_tlast !== crc_expected.done) begin
               note_mismatch($sformatf("result %0d: expected crc=%08h done=%0b, got crc=%08h done=%0b",
                                       results_checked, crc_expected.crc, crc_expected.done,
                                       rsp_tdata, rsp_tlast));
            end
         end
      end
   end

   // Present one byte, wait for its transaction and record the expected remainder.
   // When use_crc is set the remainder typed in the table replaces the prediction.
   task automatic push_byte(input logic [BYTE_W-1:0] data, input logic first,
                            input logic last, input logic use_crc,
                            input logic [CRC_W-1:0] typed_crc);
      logic [CRC_W-1:0] mask;
      logic [CRC_W-1:0] r;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      mask = crc_wide ? MASK32 : MASK16;
      r = (first ? crc_start : crc_remainder) & mask;
      r = fold_crc_byte(r, data, crc_poly & mask) & mask;
      crc_remainder = r;
      crc_expect_q.push_back('{crc: use_crc ? typed_crc : r, done: last});
   endtask

   // Stop sending and wait until every expected remainder has come back.
   task automatic drain_engine();
      req_tvalid <= 1'b0;
      while (crc_expect_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CRC_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      csr_writes++;
      case (index)
         CSR_POLYNOMIAL:  crc_poly  = value;
         CSR_WIDTH_MODE:  crc_wide  = value[0];
         CSR_START_VALUE: crc_start = value;
         default: ;
      endcase
   endtask

   // A new random setting of all registers, extremes favored.
   task automatic pick_settings();
      logic [CRC_W-1:0] poly;
      logic [CRC_W-1:0] start;
      case ($urandom_range(5))
         0:       poly = POLY_RESET;
         1:       poly = 32'h0000_A001;
         2:       poly = 32'h0000_8408;
         3:       poly = 32'h0000_0000;
         4:       poly = 32'hFFFF_FFFF;
         default: poly = $urandom;
      endcase
      case ($urandom_range(2))
         0:       start = 32'h0000_0000;
         1:       start = 32'hFFFF_FFFF;
         default: start = $urandom;
      endcase
      write_csr(CSR_POLYNOMIAL, poly);
      write_csr(CSR_WIDTH_MODE, {31'b0, $urandom_range(1) == 1 ? WIDTH_32 : WIDTH_16});
      write_csr(CSR_START_VALUE, start);
   endtask

   // Mostly whole messages with random bytes; one item in ten carries random marks.
   task automatic send_random_stream(input int unsigned count);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            push_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'b0, '0);
            sent++;
         end else begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
               push_byte(BYTE_W'($urandom_range(255)), k == 0, k == len - 1, 1'b0, '0);
            end
            sent += len;
            messages_sent++;
         end
      end
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = 1'b0;
      req_tlast       = 1'b0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      crc_poly        = POLY_RESET;
      crc_wide        = WIDTH_RESET;
      crc_start       = START_RESET;
      crc_remainder   = '0;
      req_idle_pct    = 21;
      rsp_idle_pct    = 63;
      bytes_sent      = 0;
      results_checked = 0;
      messages_sent   = 0;
      csr_writes      = 0;
      mismatch_count  = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table.
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_CSR) begin
            drain_engine();
            write_csr(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].value);
         end else begin
            push_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].has_crc, DIRECTED_ROWS[i].crc);
         end
      end

      // Random part: three idle patterns, four register settings each.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 21;
               rsp_idle_pct = 63;
            end
            1: begin
               req_idle_pct = 63;
               rsp_idle_pct = 21;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int setting = 0; setting < 4; setting++) begin
            drain_engine();
            pick_settings();
            send_random_stream(42);
         end
      end

      drain_engine();
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes (%0d random messages), checked %0d remainders, %0d register writes.",
               bytes_sent, messages_sent, results_checked, csr_writes);
      $display("Both width modes, extreme polynomials and start values, three idle patterns; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && crc_expect_q.size() == 0) begin
         $display("** reflected_crc_byte_engine_core: PASSED **");
      end else begin
         $display("** reflected_crc_byte_engine_core: FAILED **");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #400000;
      $display("Timeout with %0d remainders still expected.", crc_expect_q.size());
      $display("** reflected_crc_byte_engine_core: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
